// File: hdl/cpi_pkg.sv
`timescale 1ns / 1ps

package cpi_pkg;

   // Command line bound, counted with its prefix: a line keeps at most LINE_MAX-1 bytes.
   localparam int LINE_MAX   = 64;
   localparam int LEN_W      = $clog2(LINE_MAX);
   localparam int PREFIX_LEN = 4;
   localparam int PM_W       = $clog2(PREFIX_LEN);
   localparam int CNT_W      = $clog2(PREFIX_LEN + 1);

   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   localparam logic [1:0] KIND_FWD = 2'd0;
   localparam logic [1:0] KIND_CMD = 2'd1;
   localparam logic [1:0] KIND_END = 2'd2;

   typedef struct packed {
      logic [PM_W-1:0]  prefix_matched;
      logic             in_command;
      logic [LEN_W-1:0] line_length;
   } state_type;

   // Words caused by one input byte: the first held_cnt prefix bytes, then
   // the current byte if cur_vld.
   typedef struct packed {
      logic [PM_W-1:0] held_cnt;
      logic [7:0]      cur_byte;
      logic [1:0]      cur_kind;
      logic            cur_vld;
   } burst_type;

   typedef struct packed {
      state_type state;
      burst_type burst;
   } step_type;

   // Escape prefix "$CB:".
   function automatic logic [7:0] prefix_byte(input logic [PM_W-1:0] idx);
      logic [7:0] b;
      unique case (idx)
         2'd0:    b = 8'h24;
         2'd1:    b = 8'h43;
         2'd2:    b = 8'h42;
         default: b = 8'h3A;
      endcase
      return b;
   endfunction

endpackage

// File: hdl/cpi_classify.sv
`timescale 1ns / 1ps

module cpi_classify (
   input  logic                 fwd_en,
   input  logic [7:0]           in_byte,
   input  cpi_pkg::state_type   state,
   output cpi_pkg::step_type    step
);

   logic is_nl;

   assign is_nl = (in_byte == cpi_pkg::CHAR_LF) || (in_byte == cpi_pkg::CHAR_CR);

   always_comb begin
      step.state          = state;
      step.burst.held_cnt = '0;
      step.burst.cur_byte = in_byte;
      step.burst.cur_kind = cpi_pkg::KIND_FWD;
      step.burst.cur_vld  = 1'b0;

      if (is_nl) begin
         // end the line, or flush held prefix bytes ahead of the newline if forwarding is enabled
         if (state.in_command) begin
            step.burst.cur_byte = 8'h00;
            step.burst.cur_kind = cpi_pkg::KIND_END;
            step.burst.cur_vld  = 1'b1;
         end else begin
            step.burst.held_cnt = fwd_en ? state.prefix_matched : '0;
            step.burst.cur_vld  = fwd_en;
         end
         step.state = '0;
      end else if (state.in_command) begin
         if (state.line_length < cpi_pkg::LEN_W'(cpi_pkg::LINE_MAX - 1)) begin
            step.state.line_length = state.line_length + 1'b1;
            step.burst.cur_kind    = cpi_pkg::KIND_CMD;
            step.burst.cur_vld     = 1'b1;
         end
      end else if (in_byte == cpi_pkg::prefix_byte(state.prefix_matched)) begin
         if (state.prefix_matched == cpi_pkg::PM_W'(cpi_pkg::PREFIX_LEN - 1)) begin
            step.state.prefix_matched = '0;
            step.state.in_command     = 1'b1;
            step.state.line_length    = cpi_pkg::LEN_W'(cpi_pkg::PREFIX_LEN);
         end else begin
            step.state.prefix_matched = state.prefix_matched + 1'b1;
         end
      end else begin
         // mismatch: release held bytes and the current byte if forwarding is enabled
         step.burst.held_cnt       = fwd_en ? state.prefix_matched : '0;
         step.burst.cur_vld        = fwd_en;
         step.state.prefix_matched = '0;
      end
   end

endmodule

// File: hdl/command_prefix_interceptor_unit.sv
`timescale 1ns / 1ps

// A result word is registered: it appears in the cycle after its input word
// is taken. One input word is taken per cycle while each word causes at most
// one result and the output is not stalled; a word that flushes k held prefix
// bytes holds the output register, and the input waits, until its last word leaves.
// Reset (synchronous, active high): clear the prefix match, command mode,
// line length, forward enable and the pending output burst.
module command_prefix_interceptor_unit (
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_we,
   input  logic       csr_wdata,     // forward_enable
   // host byte stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,     // [7:0] in_byte
   // result stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,     // [7:0] out_byte
   output logic [1:0] rsp_tuser,     // [1:0] out_kind
   output logic       rsp_tlast      // last_of_run
);

   logic                      fwd_en_ff;
   cpi_pkg::state_type        state_ff;
   cpi_pkg::step_type         step;

   // Output burst register: holds every word caused by one input word.
   cpi_pkg::burst_type        burst_ff;
   logic                      busy_ff;
   logic [cpi_pkg::PM_W-1:0]  pos_ff;
   logic [cpi_pkg::PM_W-1:0]  pos_in;

   logic [cpi_pkg::CNT_W-1:0] total;
   logic [cpi_pkg::CNT_W-1:0] new_total;
   logic                      in_fire;
   logic                      out_fire;
   logic                      at_last;

   // Work out next state and the words for this byte in one pass.
   cpi_classify u_classify (
      .fwd_en  (fwd_en_ff),
      .in_byte (req_tdata),
      .state   (state_ff),
      .step    (step)
   );

   assign total     = cpi_pkg::CNT_W'(burst_ff.held_cnt) + cpi_pkg::CNT_W'(burst_ff.cur_vld);
   assign new_total = cpi_pkg::CNT_W'(step.burst.held_cnt)
                    + cpi_pkg::CNT_W'(step.burst.cur_vld);
   assign at_last   = (cpi_pkg::CNT_W'(pos_ff) + 1'b1) == total;

   assign out_fire  = rsp_tvalid && rsp_tready;
   // Take a new word when the output register is empty or drains this cycle.
   assign req_tready = !busy_ff || (out_fire && at_last);
   assign in_fire    = req_tvalid && req_tready;

   assign pos_in = pos_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_en_ff <= 1'b0;
      end else if (csr_we) begin
         fwd_en_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (in_fire) begin
         state_ff <= step.state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= '0;
      end else if (in_fire) begin
         // load a fresh burst; a word with no result leaves it empty
         busy_ff <= (new_total != '0);
         pos_ff  <= '0;
      end else if (out_fire) begin
         // advance through the burst, drop it after the last word
         busy_ff <= !at_last;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         burst_ff <= step.burst;
      end
   end

   // Held prefix bytes go out first, then the current byte.
   always_comb begin
      if (cpi_pkg::CNT_W'(pos_ff) < cpi_pkg::CNT_W'(burst_ff.held_cnt)) begin
         rsp_tdata = cpi_pkg::prefix_byte(pos_ff);
         rsp_tuser = cpi_pkg::KIND_FWD;
      end else begin
         rsp_tdata = burst_ff.cur_byte;
         rsp_tuser = burst_ff.cur_kind;
      end
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tlast  = at_last;

   // A pending burst never points past its own last word.
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (cpi_pkg::CNT_W'(pos_ff) < total))
      else $error("burst position beyond burst length");

   // An end marker is always the only and last word of its burst.
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == cpi_pkg::KIND_END) |-> (rsp_tlast && pos_ff == '0))
      else $error("end marker not alone in its burst");

   // Input stalls only while a burst is still draining.
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (busy_ff && !(out_fire && at_last)))
      else $error("input stalled with no burst draining");

   // Reset leaves the output empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid right after reset");

endmodule
